>>> rtl/core/linear_interp_resampler_assert.svh
// ----------------------------------------------------------------------------
// Resampler assertion macros
// Property wrappers used by the resampler sequencer.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// same-cycle implication
`define LIR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lir assertion failed");

// next-cycle implication
`define LIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lir assertion failed");

`endif

>>> rtl/core/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types, constants and sample helpers for the resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lir_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int PHASE_W   = 25;
  localparam int STEP_W    = 24;
  localparam int CHAN_W    = 2;
  localparam int FMT_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_RUN   = 64;
  localparam int RUN_CNT_W = 6;

  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd2;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;
  localparam logic [CHAN_W-1:0] CHAN_MONO  = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;
  localparam logic [FMT_W-1:0]  FMT_RESET  = FMT_S16;

  typedef struct packed {
    logic [STEP_W-1:0] phase_step;
    logic [CHAN_W-1:0] channel_count;
    logic [FMT_W-1:0]  sample_format;
  } cfg_t;

  typedef struct packed {
    logic                prime;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
  } frame_t;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [PHASE_W-1:0]  phase;
    logic [SAMPLE_W-1:0] prev_left;
    logic [SAMPLE_W-1:0] prev_right;
    logic [SAMPLE_W-1:0] cur_left;
    logic [SAMPLE_W-1:0] cur_right;
  } issue_t;

  function automatic logic [SAMPLE_W-1:0] fmt_mask(input logic [FMT_W-1:0] fmt);
    logic [SAMPLE_W-1:0] m;
    case (fmt)
      FMT_U8:  m = 32'h0000_00FF;
      FMT_S16: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic signed [SAMPLE_W:0] decode(input logic [SAMPLE_W-1:0] raw,
                                                      input logic [FMT_W-1:0] fmt);
    logic signed [SAMPLE_W:0] v;
    case (fmt)
      FMT_U8:  v = {25'd0, raw[7:0]};
      FMT_S16: v = {{17{raw[15]}}, raw[15:0]};
      default: v = {raw[31], raw};
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear-interpolation sample-rate converter for mono or stereo frames,
// 9.16 fixed-point phase, up to 64 output words per input word.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: sample_left, sample_right
//  m_axis    out  m_axis_tvalid/tready      tdata: out_left, out_right;
//                                           tlast: last_of_run
//  cfg       in   cfg_wr_en                 cfg_index, cfg_wr_data
//
// Each input word takes an idle step in the sequencer, then a run state
// for its output words; priming and dropped (downsampling) words take the
// idle step only. Issued words leave through the five-stage multiply pipeline.
// A two-word frame queue takes input words ahead of the sequencer;
// s_axis_tready drops only while both entries are held.
// Back-pressure on m_axis freezes the sequencer and the whole pipeline.
// Reset is synchronous; config returns to defaults, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_interp_resampler #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [2*lir_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // sample_left, sample_right
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [2*lir_pkg::SAMPLE_W-1:0]    m_axis_tdata,  // out_left, out_right
  output logic                              m_axis_tlast,
  input  logic                              cfg_wr_en,
  input  logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lir_pkg::STEP_W-1:0]        cfg_wr_data
);

  localparam int SW = lir_pkg::SAMPLE_W;

  lir_pkg::cfg_t   cfg;
  lir_pkg::frame_t push_frame;
  lir_pkg::frame_t head;
  lir_pkg::issue_t issue;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  logic            adv;
  logic [SW-1:0]   out_left;
  logic [SW-1:0]   out_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step    <= lir_pkg::STEP_RESET;
      cfg.channel_count <= lir_pkg::CHAN_RESET;
      cfg.sample_format <= lir_pkg::FMT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lir_pkg::REG_PHASE_STEP:    cfg.phase_step    <= cfg_wr_data;
        lir_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= cfg_wr_data[lir_pkg::CHAN_W-1:0];
        lir_pkg::REG_SAMPLE_FORMAT: cfg.sample_format <= cfg_wr_data[lir_pkg::FMT_W-1:0];
        default:                    cfg <= cfg;
      endcase
    end
  end

  lir_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_left    (s_axis_tdata[SW-1:0]),
    .in_right   (s_axis_tdata[2*SW-1:SW]),
    .q_full     (q_full),
    .push       (push),
    .push_frame (push_frame)
  );

  lir_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  lir_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .phase_step (cfg.phase_step),
    .adv        (adv),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .issue      (issue)
  );

  lir_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .issue     (issue),
    .adv       (adv),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_left  (out_left),
    .out_right (out_right),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_right, out_left};

endmodule

>>> rtl/core/lir_front.sv
// ----------------------------------------------------------------------------
// lir_front
// Input side: masks raw samples to the format, zeroes the right channel
// for mono and tags the first word after reset as a priming frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_front (
  input  logic                           clk,
  input  logic                           rst,
  input  lir_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lir_pkg::SAMPLE_W-1:0]   in_left,
  input  logic [lir_pkg::SAMPLE_W-1:0]   in_right,
  input  logic                           q_full,
  output logic                           push,
  output lir_pkg::frame_t                push_frame
);

  logic                         primed;
  logic [lir_pkg::SAMPLE_W-1:0] mask;

  assign mask     = lir_pkg::fmt_mask(cfg.sample_format);
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_frame.prime = !primed;
    push_frame.left  = in_left & mask;
    push_frame.right = (cfg.channel_count == lir_pkg::CHAN_MONO) ? '0 : (in_right & mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (push) begin
      primed <= 1'b1;
    end
  end

endmodule

>>> rtl/core/lir_fifo.sv
// ----------------------------------------------------------------------------
// lir_fifo
// Two-entry frame queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lir_pkg::frame_t push_frame,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output lir_pkg::frame_t head
);

  lir_pkg::frame_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/lir_seq.sv
// ----------------------------------------------------------------------------
// lir_seq
// Back-end sequencer: holds phase and previous frame, walks each queued frame's
// run, issuing one interpolation per cycle while adv is high and q_empty is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_seq #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lir_pkg::STEP_W-1:0]    phase_step,
  input  logic                          adv,
  input  logic                          q_empty,
  input  lir_pkg::frame_t               head,
  output logic                          pop,
  output lir_pkg::issue_t               issue
);

  localparam int PW = lir_pkg::PHASE_W;
  localparam int CW = lir_pkg::RUN_CNT_W;
  localparam logic [PW-1:0] ONE      = PW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] CNT_LAST = CW'(lir_pkg::MAX_RUN - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                         state;
  logic [PW-1:0]                phase;
  logic [CW-1:0]                cnt;
  logic [lir_pkg::SAMPLE_W-1:0] prev_left;
  logic [lir_pkg::SAMPLE_W-1:0] prev_right;
  logic [PW-1:0]                step_sum;
  logic                         step_over;
  logic                         run_end;
  logic                         take;

  assign step_sum  = phase + PW'(phase_step);
  assign step_over = (step_sum >= ONE);
  assign run_end   = step_over || (cnt == CNT_LAST);
  assign take      = adv && !q_empty;

  always_comb begin
    pop = 1'b0;
    case (state)
      S_IDLE:  pop = take && (head.prime || (phase >= ONE));
      S_RUN:   pop = take && run_end;
      default: pop = 1'b0;
    endcase
  end

  always_comb begin
    issue.valid      = (state == S_RUN) && take;
    issue.last       = run_end;
    issue.phase      = phase;
    issue.prev_left  = prev_left;
    issue.prev_right = prev_right;
    issue.cur_left   = head.left;
    issue.cur_right  = head.right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= '0;
      cnt        <= '0;
      prev_left  <= '0;
      prev_right <= '0;
    end else if (take) begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (head.prime) begin
            prev_left  <= head.left;
            prev_right <= head.right;
          end else if (phase >= ONE) begin
            phase      <= phase - ONE;
            prev_left  <= head.left;
            prev_right <= head.right;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          cnt <= cnt + CW'(1);
          if (run_end) begin
            phase      <= step_over ? (step_sum - ONE) : '0;
            prev_left  <= head.left;
            prev_right <= head.right;
            state      <= S_IDLE;
          end else begin
            phase <= step_sum;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "linear_interp_resampler_assert.svh"

  `LIR_ASSERT_NOW(a_issue_in_run, issue.valid, state == S_RUN)
  `LIR_ASSERT_NEXT(a_last_to_idle, issue.valid && issue.last, state == S_IDLE)
  `LIR_ASSERT_NOW(a_pop_nonempty, pop, !q_empty)

endmodule

>>> rtl/core/lir_interp.sv
// ----------------------------------------------------------------------------
// lir_interp
// Five-stage interpolation pipeline, both channels side by side: decode,
// magnitude, split multiply, sum and shift, signed add into the output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_interp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lir_pkg::cfg_t                 cfg,
  input  lir_pkg::issue_t               issue,
  output logic                          adv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lir_pkg::SAMPLE_W-1:0]  out_left,
  output logic [lir_pkg::SAMPLE_W-1:0]  out_right,
  output logic                          out_last
);

  localparam int SW = lir_pkg::SAMPLE_W;
  localparam int HW = SW / 2;
  localparam int PPW = HW + FRAC_BITS;
  localparam int SUMW = SW + FRAC_BITS;

  logic [SW-1:0] prev_raw [2];
  logic [SW-1:0] cur_raw  [2];

  logic                 v_a, v_b, v_c, v_d, v_e;
  logic                 last_a, last_b, last_c, last_d;
  logic [FRAC_BITS-1:0] frac_a, frac_b;

  logic signed [SW:0]   a_a [2];
  logic signed [SW:0]   d_a [2];
  logic signed [SW:0]   a_b [2];
  logic [SW-1:0]        mag_b [2];
  logic                 neg_b [2];
  logic signed [SW:0]   a_c [2];
  logic [PPW-1:0]       pp_lo_c [2];
  logic [PPW-1:0]       pp_hi_c [2];
  logic                 neg_c [2];
  logic signed [SW:0]   a_d [2];
  logic [SW-1:0]        q_d [2];
  logic                 neg_d [2];
  logic [SW-1:0]        res_e [2];

  logic [SUMW-1:0]      prod_sum [2];
  logic [SW:0]          fin_sum [2];
  logic [SW-1:0]        mask;

  assign adv   = !v_e || out_ready;
  assign mask  = lir_pkg::fmt_mask(cfg.sample_format);

  assign prev_raw[0] = issue.prev_left;
  assign prev_raw[1] = issue.prev_right;
  assign cur_raw[0]  = issue.cur_left;
  assign cur_raw[1]  = issue.cur_right;

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      prod_sum[ch] = {pp_hi_c[ch], HW'(0)} + SUMW'(pp_lo_c[ch]);
      fin_sum[ch]  = neg_d[ch] ? (a_d[ch] - $signed({1'b0, q_d[ch]}))
                               : (a_d[ch] + $signed({1'b0, q_d[ch]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
    end else if (adv) begin
      v_a <= issue.valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
      v_e <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_a   <= issue.last;
      frac_a   <= issue.phase[FRAC_BITS-1:0];
      last_b   <= last_a;
      frac_b   <= frac_a;
      last_c   <= last_b;
      last_d   <= last_c;
      out_last <= last_d;
      for (int ch = 0; ch < 2; ch++) begin
        a_a[ch]     <= lir_pkg::decode(prev_raw[ch], cfg.sample_format);
        d_a[ch]     <= lir_pkg::decode(cur_raw[ch], cfg.sample_format)
                       - lir_pkg::decode(prev_raw[ch], cfg.sample_format);
        a_b[ch]     <= a_a[ch];
        neg_b[ch]   <= d_a[ch][SW];
        mag_b[ch]   <= d_a[ch][SW] ? SW'(-d_a[ch]) : d_a[ch][SW-1:0];
        a_c[ch]     <= a_b[ch];
        neg_c[ch]   <= neg_b[ch];
        pp_lo_c[ch] <= mag_b[ch][HW-1:0] * frac_b;
        pp_hi_c[ch] <= mag_b[ch][SW-1:HW] * frac_b;
        a_d[ch]     <= a_c[ch];
        neg_d[ch]   <= neg_c[ch];
        q_d[ch]     <= prod_sum[ch][FRAC_BITS +: SW];
        res_e[ch]   <= fin_sum[ch][SW-1:0] & mask;
      end
    end
  end

  assign out_valid = v_e;
  assign out_left  = res_e[0];
  assign out_right = (cfg.channel_count == lir_pkg::CHAN_MONO) ? '0 : res_e[1];

endmodule

>>> sim/lir_checker.sv
// ----------------------------------------------------------------------------
// lir_checker
// Watches the config port and both stream channels of the resampler,
// predicts every output word from the accepted frames and compares each
// accepted output word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [2*lir_pkg::SAMPLE_W-1:0] s_axis_tdata,  // sample_left, sample_right
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [2*lir_pkg::SAMPLE_W-1:0] m_axis_tdata,  // out_left, out_right
  input  logic                          m_axis_tlast,
  input  logic                          cfg_wr_en,
  input  logic [lir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lir_pkg::STEP_W-1:0]    cfg_wr_data,
  output int                            outstanding,
  output int                            mismatches
);

  localparam int SAMPLE_W = lir_pkg::SAMPLE_W;
  localparam int PHASE_W  = lir_pkg::PHASE_W;
  localparam int CHAN_W   = lir_pkg::CHAN_W;
  localparam int FMT_W    = lir_pkg::FMT_W;
  localparam int MAX_RUN  = lir_pkg::MAX_RUN;

  localparam logic [PHASE_W-1:0] ONE = PHASE_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                last;
  } out_word_t;

  out_word_t           due_words[$];
  out_word_t           head;
  lir_pkg::cfg_t       cfg;
  logic [SAMPLE_W-1:0] prev_left;
  logic [SAMPLE_W-1:0] prev_right;
  logic [PHASE_W-1:0]  phase;
  logic                primed;
  int                  fails = 0;

  function automatic logic [SAMPLE_W-1:0] sample_mask(input logic [FMT_W-1:0] fmt);
    logic [SAMPLE_W-1:0] m;
    case (fmt)
      lir_pkg::FMT_U8:  m = 32'h0000_00FF;
      lir_pkg::FMT_S16: m = 32'h0000_FFFF;
      default:          m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic longint to_value(input logic [SAMPLE_W-1:0] raw,
                                      input logic [FMT_W-1:0] fmt);
    longint v;
    case (fmt)
      lir_pkg::FMT_U8: begin
        v = raw[7:0];
      end
      lir_pkg::FMT_S16: begin
        v = raw[15:0];
        if (raw[15]) v = v - 64'sd65536;
      end
      default: begin
        v = raw;
        if (raw[31]) v = v - 64'sd4294967296;
      end
    endcase
    return v;
  endfunction

  // prev + (cur - prev) * frac / ONE, quotient truncated toward zero
  function automatic logic [SAMPLE_W-1:0] blend(input logic [SAMPLE_W-1:0] prev,
                                                input logic [SAMPLE_W-1:0] cur,
                                                input logic [PHASE_W-1:0]  frac,
                                                input logic [FMT_W-1:0]    fmt);
    longint     base;
    longint     prod;
    longint     delta;
    logic [63:0] sum;
    base = to_value(prev, fmt);
    prod = (to_value(cur, fmt) - base) * longint'(frac);
    if (prod < 0) delta = -((-prod) >>> FRAC_BITS);
    else delta = prod >>> FRAC_BITS;
    sum = base + delta;
    return sum[SAMPLE_W-1:0] & sample_mask(fmt);
  endfunction

  task automatic resample_frame(input logic [SAMPLE_W-1:0] raw_left,
                                input logic [SAMPLE_W-1:0] raw_right);
    logic                mono;
    logic [SAMPLE_W-1:0] cur_left;
    logic [SAMPLE_W-1:0] cur_right;
    int                  n;
    out_word_t           w;
    mono      = (cfg.channel_count == lir_pkg::CHAN_MONO);
    cur_left  = raw_left & sample_mask(cfg.sample_format);
    cur_right = mono ? '0 : raw_right & sample_mask(cfg.sample_format);
    if (primed) begin
      n = 0;
      while (phase < ONE && n < MAX_RUN) begin
        w.left  = blend(prev_left, cur_left, phase, cfg.sample_format);
        w.right = mono ? '0 : blend(prev_right, cur_right, phase, cfg.sample_format);
        phase   = phase + cfg.phase_step;
        n++;
        w.last  = (phase >= ONE) || (n == MAX_RUN);
        due_words.push_back(w);
      end
      // capped run: surplus outputs are dropped
      if (phase < ONE) phase = ONE;
      phase = phase - ONE;
    end
    primed     = 1'b1;
    prev_left  = cur_left;
    prev_right = cur_right;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.phase_step    = lir_pkg::STEP_RESET;
      cfg.channel_count = lir_pkg::CHAN_RESET;
      cfg.sample_format = lir_pkg::FMT_RESET;
      prev_left         = '0;
      prev_right        = '0;
      phase             = '0;
      primed            = 1'b0;
      due_words.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          lir_pkg::REG_PHASE_STEP:    cfg.phase_step    = cfg_wr_data;
          lir_pkg::REG_CHANNEL_COUNT: cfg.channel_count = cfg_wr_data[CHAN_W-1:0];
          lir_pkg::REG_SAMPLE_FORMAT: cfg.sample_format = cfg_wr_data[FMT_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_words.size() == 0) begin
          fails++;
          $error("output word with none due: out_left %h out_right %h last_of_run %b",
                 m_axis_tdata[SAMPLE_W-1:0], m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W],
                 m_axis_tlast);
        end else begin
          head = due_words.pop_front();
          if (m_axis_tdata[SAMPLE_W-1:0] !== head.left) begin
            fails++;
            $error("out_left: expected %h, got %h", head.left, m_axis_tdata[SAMPLE_W-1:0]);
          end
          if (m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W] !== head.right) begin
            fails++;
            $error("out_right: expected %h, got %h", head.right,
                   m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
          end
          if (m_axis_tlast !== head.last) begin
            fails++;
            $error("last_of_run: expected %b, got %b", head.last, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        resample_frame(s_axis_tdata[SAMPLE_W-1:0], s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
    end
    outstanding <= due_words.size();
    mismatches  <= fails;
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives frames and config writes into the resampler with random gaps on
// both channels: a directed pass over sample extremes, run caps, priming
// and downsampling, then random frames under varied step, channel and
// format settings. Checking is done by lir_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_W  = lir_pkg::SAMPLE_W;
  localparam int STEP_W    = lir_pkg::STEP_W;
  localparam int CHAN_W    = lir_pkg::CHAN_W;
  localparam int FMT_W     = lir_pkg::FMT_W;
  localparam int CFG_IDX_W = lir_pkg::CFG_IDX_W;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_FRAMES = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 32;
  localparam int STALL_LIMIT   = 2000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*SAMPLE_W-1:0]  s_axis_tdata = '0;   // sample_left, sample_right
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [2*SAMPLE_W-1:0]  m_axis_tdata;        // out_left, out_right
  logic                   m_axis_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [STEP_W-1:0]      cfg_wr_data = '0;

  int   outstanding;
  int   mismatches;
  int   stall_cycles = 0;
  int   sink_hold = 0;
  logic sink_quiet = 1'b0;
  logic src_quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  linear_interp_resampler dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data)
  );

  lir_checker frame_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .outstanding   (outstanding),
    .mismatches    (mismatches)
  );

  // output side: random hold-off after each word taken
  always @(posedge clk) begin : sink
    int gap;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= 0;
    end else if (m_axis_tready) begin
      if (m_axis_tvalid) begin
        gap = sink_quiet ? 0 : $urandom_range(12);
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          sink_hold     <= gap - 1;
        end
      end
    end else if (sink_hold == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      sink_hold <= sink_hold - 1;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    logic [SAMPLE_W-1:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: v[15:0] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      2: v[7:0] = $urandom_range(1) ? 8'h00 : 8'hFF;
      3: v = $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    logic [STEP_W-1:0] s;
    case ($urandom_range(5))
      0: s = STEP_W'($urandom_range(1024, 8191));
      1: s = STEP_W'($urandom_range(8192, 65535));
      2: s = STEP_W'($urandom_range(65536, 262143));
      3: s = STEP_W'($urandom_range(262144, 24'hFF_FFFF));
      4: s = STEP_W'($urandom_range(1023));      // runs from zero phase always reach the cap
      default: s = lir_pkg::STEP_RESET;
    endcase
    return s;
  endfunction

  task automatic send_frame(input logic [SAMPLE_W-1:0] left,
                            input logic [SAMPLE_W-1:0] right);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {right, left};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
  endtask

  // waits for the block to drain, then rewrites every register
  task automatic configure(input logic [STEP_W-1:0] step,
                           input logic [CHAN_W-1:0] chans,
                           input logic [FMT_W-1:0]  fmt);
    logic [STEP_W-1:0] junk;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(lir_pkg::REG_PHASE_STEP, step);
    junk = STEP_W'($urandom);
    junk[CHAN_W-1:0] = chans;
    write_reg(lir_pkg::REG_CHANNEL_COUNT, junk);
    junk = STEP_W'($urandom);
    junk[FMT_W-1:0] = fmt;
    write_reg(lir_pkg::REG_SAMPLE_FORMAT, junk);
    write_reg(REG_SPARE, STEP_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int frames_left;
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings; first frame only primes
    send_frame(32'h0000_7FFF, 32'h0000_8000);
    send_frame(32'h0000_8000, 32'h0000_7FFF);
    send_frame(32'hFFFF_0000, 32'h1234_FFFF);

    // wide deltas, negative products truncated toward zero
    configure(24'd24576, 2'd2, lir_pkg::FMT_S32);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000);
    send_frame(32'h8000_0000, 32'h7FFF_FFFF);
    send_frame(32'hFFFF_FFFF, 32'h0000_0000);
    send_frame(32'h0000_0000, 32'hFFFF_FFFF);

    // runs of up to 64 outputs per frame, mono unsigned
    configure(24'd1024, lir_pkg::CHAN_MONO, lir_pkg::FMT_U8);
    send_frame(32'h1234_5600, 32'h0000_00AB);
    send_frame(32'h0000_00FF, 32'h0000_0055);

    // zero step: cap on every frame; odd channel and format codes
    configure(24'd0, 2'd0, 2'd3);
    send_frame(32'h8000_0000, 32'h7FFF_FFFF);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000);

    // just under the floor: cap with outputs dropped
    configure(24'd1000, 2'd3, lir_pkg::FMT_S16);
    send_frame(32'h0000_8000, 32'h0000_7FFF);

    // largest step: long downsampling stretch
    configure(24'hFF_FFFF, 2'd2, lir_pkg::FMT_S16);
    repeat (6) send_frame(draw_sample(), draw_sample());

    frames_left = RANDOM_FRAMES;
    while (frames_left > 0) begin
      configure(pick_step(), CHAN_W'($urandom_range(3)), FMT_W'($urandom_range(3)));
      src_quiet = ($urandom_range(3) == 0);
      sink_quiet <= ($urandom_range(3) == 0);
      n = $urandom_range(8, 40);
      repeat (n) send_frame(draw_sample(), draw_sample());
      frames_left -= n;
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lir_pkg.sv
rtl/core/lir_front.sv
rtl/core/lir_fifo.sv
rtl/core/lir_seq.sv
rtl/core/lir_interp.sv
rtl/core/linear_interp_resampler.sv
sim/lir_checker.sv
sim/testbench.sv
